// File: hdl/ap_sc_pkg.sv
// Shared constants and types for the arithmetic-progression subsequence counter.
package ap_sc_pkg;

  localparam int unsigned ACC_W = 17;
  localparam logic [ACC_W-1:0] AP_MOD = 17'd100001;

  // Width of the run tag kept next to every table entry
  localparam int unsigned TAG_W = 8;

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_ROW  = 8'b0000_0100,
    S_ROWE = 8'b0000_1000,
    S_TJ   = 8'b0001_0000,
    S_TI   = 8'b0010_0000,
    S_UPD  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

endpackage

// File: hdl/ap_sc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ap_sc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/ap_subsequence_counter.sv
// Top level: loads a sequence and counts its arithmetic-progression subsequences.
//
//  channel | ports                          | direction | request moves
//  --------+--------------------------------+-----------+-------------------------
//  in      | in_valid in_ready in_value     | input     | one element, last flag
//          | in_last                        |           |
//  out     | out_valid out_ready out_count  | output    | count mod 100001 and
//          | out_overflow                   |           | overflow flag
//
// Loading accepts one element per cycle. The request marked last starts the count,
// which walks every pair (i, j), i < j, start rows from the end, through one
// table read-modify-write unit: states S_ROW and S_ROWE per row, then S_TJ,
// S_TI and S_UPD per pair; S_OUT then moves the count into the output register
// once that register is free or draining; out_valid rises the cycle after.
// After rst_n the progression table is cleared, one entry a cycle; in_ready stays low.
// Each table entry carries a run tag, so no clear is needed per run; the same
// pass repeats once every 255 runs when the tag wraps.
// in_ready is high only in S_IDLE. A result held by out stall blocks nothing
// until the next count is done; that count then waits in S_OUT.
module ap_subsequence_counter #(
  parameter int unsigned MAX_LEN    = 128,
  parameter int unsigned VALUE_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [VALUE_BITS-1:0]   in_value,
  input  logic                    in_last,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ap_sc_pkg::ACC_W-1:0] out_count,
  output logic                    out_overflow
);

  localparam int unsigned LEN_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_LEN + 1);
  localparam int unsigned D_W       = VALUE_BITS + 1;
  localparam int unsigned TBL_AW    = LEN_W + D_W;
  localparam int unsigned TBL_DEPTH = 1 << TBL_AW;
  localparam int unsigned ACC_W     = ap_sc_pkg::ACC_W;
  localparam int unsigned TAG_W     = ap_sc_pkg::TAG_W;
  localparam int unsigned WORD_W    = TAG_W + ACC_W;
  localparam logic [D_W-1:0] DOFFSET = D_W'((1 << VALUE_BITS) - 1);

  ap_sc_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [TAG_W-1:0]      epoch_r, epoch_nxt;
  logic [TBL_AW-1:0]     clr_r, clr_nxt;
  logic [LEN_W-1:0]      i_r, i_nxt;
  logic [LEN_W-1:0]      j_r, j_nxt;
  logic [VALUE_BITS-1:0] ei_r, ei_nxt;
  logic [D_W-1:0]        d_r, d_nxt;
  logic [ACC_W-1:0]      tj_r, tj_nxt;
  logic [ACC_W-1:0]      total_r, total_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [ACC_W-1:0]      out_count_r, out_count_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  // element store
  logic                  e_we, e_re;
  logic [LEN_W-1:0]      e_waddr, e_raddr;
  logic [VALUE_BITS-1:0] e_rdata;

  // progression table: {tag, count}
  logic                  t_we, t_re;
  logic [TBL_AW-1:0]     t_waddr, t_raddr;
  logic [WORD_W-1:0]     t_wdata, t_rdata;

  logic                  in_acc, out_acc, has_room;
  logic [CNT_W-1:0]      n_new;
  logic [D_W-1:0]        d_now;
  logic [ACC_W-1:0]      t_val;
  logic [ACC_W:0]        sum_t, sum_tot;
  logic [ACC_W-1:0]      new_t, new_tot;
  logic                  j_end;

  ap_sc_ram #(.WIDTH(VALUE_BITS), .DEPTH(1 << LEN_W)) u_elem (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (in_value),
    .re    (e_re),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  ap_sc_ram #(.WIDTH(WORD_W), .DEPTH(TBL_DEPTH)) u_tbl (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .re    (t_re),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  assign in_ready     = (state_r == ap_sc_pkg::S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_count    = out_count_r;
  assign out_overflow = out_ovf_r;

  assign in_acc   = in_valid & in_ready;
  assign out_acc  = out_valid_r & out_ready;
  assign has_room = (cnt_r < CNT_W'(MAX_LEN));
  assign n_new    = has_room ? cnt_r + CNT_W'(1) : cnt_r;

  // difference index of (e_i, e_j), offset so negatives land in range
  assign d_now = D_W'({1'b0, e_rdata}) + DOFFSET - D_W'({1'b0, ei_r});

  // entries from an earlier run read as zero
  assign t_val = (t_rdata[WORD_W-1 -: TAG_W] == epoch_r) ? t_rdata[ACC_W-1:0] : '0;

  // both sums stay below twice the modulus: one conditional subtract
  assign sum_t   = {1'b0, t_val}   + {1'b0, tj_r} + (ACC_W+1)'(1);
  assign sum_tot = {1'b0, total_r} + {1'b0, tj_r} + (ACC_W+1)'(1);
  assign new_t   = (sum_t   >= {1'b0, ap_sc_pkg::AP_MOD}) ?
                   ACC_W'(sum_t - {1'b0, ap_sc_pkg::AP_MOD})   : ACC_W'(sum_t);
  assign new_tot = (sum_tot >= {1'b0, ap_sc_pkg::AP_MOD}) ?
                   ACC_W'(sum_tot - {1'b0, ap_sc_pkg::AP_MOD}) : ACC_W'(sum_tot);

  assign j_end = (CNT_W'(j_r) == cnt_r - CNT_W'(1));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    epoch_nxt     = epoch_r;
    clr_nxt       = clr_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    ei_nxt        = ei_r;
    d_nxt         = d_r;
    tj_nxt        = tj_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    out_ovf_nxt   = out_ovf_r;

    if (out_acc) begin
      out_valid_nxt = 1'b0;
    end

    e_we    = 1'b0;
    e_waddr = cnt_r[LEN_W-1:0];
    e_re    = 1'b0;
    e_raddr = i_r;
    t_we    = 1'b0;
    t_waddr = {i_r, d_r};
    t_wdata = {epoch_r, new_t};
    t_re    = 1'b0;
    t_raddr = {i_r, d_r};

    case (state_r)
      ap_sc_pkg::S_CLR: begin
        t_we    = 1'b1;
        t_waddr = clr_r;
        t_wdata = '0;
        clr_nxt = clr_r + TBL_AW'(1);
        if (clr_r == TBL_AW'(TBL_DEPTH - 1)) begin
          epoch_nxt = TAG_W'(1);
          state_nxt = ap_sc_pkg::S_IDLE;
        end
      end
      ap_sc_pkg::S_IDLE: begin
        if (in_acc) begin
          e_we    = has_room;
          cnt_nxt = n_new;
          if (!has_room) begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            total_nxt = ACC_W'(n_new) + ACC_W'(1);
            if (n_new < CNT_W'(2)) begin
              state_nxt = ap_sc_pkg::S_OUT;
            end else begin
              i_nxt     = LEN_W'(n_new - CNT_W'(2));
              state_nxt = ap_sc_pkg::S_ROW;
            end
          end
        end
      end
      ap_sc_pkg::S_ROW: begin
        e_re      = 1'b1;
        e_raddr   = i_r;
        state_nxt = ap_sc_pkg::S_ROWE;
      end
      ap_sc_pkg::S_ROWE: begin
        ei_nxt    = e_rdata;
        e_re      = 1'b1;
        e_raddr   = i_r + LEN_W'(1);
        j_nxt     = i_r + LEN_W'(1);
        state_nxt = ap_sc_pkg::S_TJ;
      end
      ap_sc_pkg::S_TJ: begin
        // fetch the row-j count for this difference
        d_nxt     = d_now;
        t_re      = 1'b1;
        t_raddr   = {j_r, d_now};
        state_nxt = ap_sc_pkg::S_TI;
      end
      ap_sc_pkg::S_TI: begin
        tj_nxt    = t_val;
        t_re      = 1'b1;
        t_raddr   = {i_r, d_r};
        state_nxt = ap_sc_pkg::S_UPD;
      end
      ap_sc_pkg::S_UPD: begin
        t_we      = 1'b1;
        total_nxt = new_tot;
        e_re      = 1'b1;
        e_raddr   = j_r + LEN_W'(1);
        if (j_end) begin
          if (i_r == '0) begin
            state_nxt = ap_sc_pkg::S_OUT;
          end else begin
            i_nxt     = i_r - LEN_W'(1);
            state_nxt = ap_sc_pkg::S_ROW;
          end
        end else begin
          j_nxt     = j_r + LEN_W'(1);
          state_nxt = ap_sc_pkg::S_TJ;
        end
      end
      ap_sc_pkg::S_OUT: begin
        // hand the count over once the output register is free or draining
        if (!out_valid_r || out_acc) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = total_r;
          out_ovf_nxt   = ovf_r;
          cnt_nxt       = '0;
          ovf_nxt       = 1'b0;
          total_nxt     = '0;
          epoch_nxt     = epoch_r + TAG_W'(1);
          if (epoch_r == '1) begin
            clr_nxt   = '0;
            state_nxt = ap_sc_pkg::S_CLR;
          end else begin
            state_nxt = ap_sc_pkg::S_IDLE;
          end
        end
      end
      default: begin
        clr_nxt   = '0;
        state_nxt = ap_sc_pkg::S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ap_sc_pkg::S_CLR;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      epoch_r     <= '0;
      clr_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      out_count_r <= '0;
      out_ovf_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      epoch_r     <= epoch_nxt;
      clr_r       <= clr_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      out_count_r <= out_count_nxt;
      out_ovf_r   <= out_ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r  <= i_nxt;
    j_r  <= j_nxt;
    ei_r <= ei_nxt;
    d_r  <= d_nxt;
    tj_r <= tj_nxt;
  end

endmodule
